/* hw/rtl/tcw_pkg.sv */
// Shared types, constants and helpers for the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CELL_W    = 16;

  // Result field widths
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;
  localparam int OUT_POS_W = 11;

  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END  = ADDR_W'(CELLS - COLUMNS);

  // Cell written by the power-on clearing pass: space, light grey on black
  localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Command codes
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_SETCUR = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [7:0] row_in;
    logic [7:0] col_in;
  } cmd_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [OUT_POS_W-1:0] cursor_position;
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_data;
  } res_t;

  // Decoded action of one request, from the cursor unit to the sequencer
  typedef struct packed {
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_next;
    logic              cell_we;
    logic              blank;
    logic              scroll;
    logic              clear;
    logic              read;
    logic [ADDR_W-1:0] addr;
  } act_t;

  // Linear cell index of a row and column
  function automatic logic [ADDR_W-1:0] cell_pos(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_cursor.sv */
// Cursor unit: decodes a request into the next cursor and the cell access it needs.
`default_nettype none

module tcw_cursor
  import tcw_pkg::*;
(
  input  wire cmd_t             req,
  input  wire logic [ROW_W-1:0] cur_row,
  input  wire logic [COL_W-1:0] cur_col,
  output act_t                  act
);

  logic [ROW_W:0]   row_inc;
  logic [COL_W:0]   col_inc;
  logic [COL_W:0]   tab_col;
  logic             nl_scroll;
  logic [ROW_W-1:0] nl_row;
  logic [ROW_W-1:0] r_sat;
  logic [COL_W-1:0] c_sat;
  logic [ROW_W-1:0] addr_row;
  logic [COL_W-1:0] addr_col;

  // Step to the next line, saturating at the bottom row with a scroll
  assign row_inc   = {1'b0, cur_row} + (ROW_W+1)'(1);
  assign nl_scroll = row_inc >= (ROW_W+1)'(ROWS);
  assign nl_row    = nl_scroll ? LAST_ROW : row_inc[ROW_W-1:0];

  assign col_inc = {1'b0, cur_col} + (COL_W+1)'(1);
  assign tab_col = ({1'b0, cur_col} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);

  // Saturate the target cell to the screen
  assign r_sat = (req.row_in > 8'(ROWS - 1))    ? LAST_ROW : ROW_W'(req.row_in);
  assign c_sat = (req.col_in > 8'(COLUMNS - 1)) ? LAST_COL : COL_W'(req.col_in);

  // Decode the request
  always_comb begin
    act          = '0;
    act.row_next = cur_row;
    act.col_next = cur_col;
    addr_row     = cur_row;
    addr_col     = cur_col;
    unique case (req.command)
      CMD_PUT: begin
        unique case (req.char_code)
          CH_NL: begin
            act.row_next = nl_row;
            act.col_next = '0;
            act.scroll   = nl_scroll;
          end
          CH_CR: begin
            act.col_next = '0;
          end
          CH_BS: begin
            if (cur_col != '0) begin
              act.col_next = cur_col - COL_W'(1);
              addr_col     = cur_col - COL_W'(1);
              act.cell_we  = 1'b1;
              act.blank    = 1'b1;
            end
          end
          CH_TAB: begin
            if (tab_col >= (COL_W+1)'(COLUMNS)) begin
              act.row_next = nl_row;
              act.col_next = '0;
              act.scroll   = nl_scroll;
            end else begin
              act.col_next = tab_col[COL_W-1:0];
            end
          end
          default: begin
            act.cell_we = 1'b1;
            if (col_inc >= (COL_W+1)'(COLUMNS)) begin
              act.row_next = nl_row;
              act.col_next = '0;
              act.scroll   = nl_scroll;
            end else begin
              act.col_next = col_inc[COL_W-1:0];
            end
          end
        endcase
      end
      CMD_CLEAR: begin
        act.row_next = '0;
        act.col_next = '0;
        act.clear    = 1'b1;
      end
      CMD_SETCUR: begin
        act.row_next = r_sat;
        act.col_next = c_sat;
      end
      CMD_READ: begin
        act.read = 1'b1;
        addr_row = r_sat;
        addr_col = c_sat;
      end
      default: ;
    endcase
    act.addr = cell_pos(addr_row, addr_col);
  end

endmodule

`default_nettype wire

/* hw/rtl/text_console_writer_unit.sv */
// Top level of the text console writer: sequencer, cursor, colors and text store.
//
// Character-cell console holding a ROWS x COLUMNS store of 16-bit cells
// (attribute high byte, character low byte) and a cursor. After reset a
// clearing pass writes a blank cell to each of the CELLS entries (2000 at
// 80 x 25), one a cycle; no request is taken meanwhile, while color writes
// are. Set cursor and put character without a scroll go from acceptance to
// the done state; read cell passes a read state first for the registered RAM
// read. Clear screen blanks every entry, one store write per cycle. A scroll
// copies each cell one row up through the single RAM read port, one cell a
// cycle, then blanks the bottom row. The request channel is ready only while
// the sequencer is idle; a finished result waits in the output register and
// the next request may be taken behind it.
`default_nettype none

module text_console_writer_unit
  import tcw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire cmd_t       cmd,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data
);

  state_t state, state_next;

  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [3:0]        fg;
  logic [3:0]        bg;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] wdst;
  logic              pend;
  logic              scrolled;
  logic [CELL_W-1:0] read_data;

  act_t              act;
  logic              accept;
  logic              res_free;
  logic [CELL_W-1:0] blank_cell;
  logic [CELL_W-1:0] char_cell;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cmd_ready  = (state == ST_IDLE);
  assign accept     = cmd_valid && cmd_ready;
  assign res_free   = !res_valid || res_ready;
  assign blank_cell = {bg, fg, CH_SPACE};
  assign char_cell  = {bg, fg, cmd.char_code};

  tcw_cursor u_cursor (
    .req     (cmd),
    .cur_row (cur_row),
    .cur_col (cur_col),
    .act     (act)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequence the store accesses and pick the next state
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = blank_cell;
    ram_raddr  = act.addr;
    unique case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        if (cnt == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_we    = accept && act.cell_we;
        ram_waddr = act.addr;
        ram_wdata = act.blank ? blank_cell : char_cell;
        if (accept) begin
          if (act.clear) begin
            state_next = ST_CLEAR;
          end else if (act.read) begin
            state_next = ST_READ;
          end else if (act.scroll) begin
            state_next = ST_SCROLL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_SCROLL: begin
        ram_we    = pend;
        ram_waddr = wdst;
        ram_wdata = ram_rdata;
        ram_raddr = ADDR_W'({1'b0, cnt} + (ADDR_W+1)'(COLUMNS));
        if (cnt == SCROLL_END) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (cnt == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Advance the counter, cursor and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      cur_row   <= '0;
      cur_col   <= '0;
      fg        <= 4'd7;
      bg        <= 4'd0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FG:  fg <= cfg_data;
          CFG_BG:  bg <= cfg_data;
          default: ;
        endcase
      end

      // Drop a taken result unless a new one replaces it below
      if (res_valid && res_ready && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_INIT, ST_CLEAR, ST_BLANK: begin
          if (cnt == LAST_CELL) begin
            cnt <= '0;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_row   <= act.row_next;
            cur_col   <= act.col_next;
            scrolled  <= act.scroll;
            read_data <= '0;
          end
        end
        ST_READ: begin
          read_data <= ram_rdata;
        end
        ST_SCROLL: begin
          if (cnt == SCROLL_END) begin
            pend <= 1'b0;
          end else begin
            pend <= 1'b1;
            wdst <= cnt;
            cnt  <= cnt + ADDR_W'(1);
          end
        end
        ST_DONE: begin
          if (res_free) begin
            res_valid           <= 1'b1;
            res.cursor_row      <= OUT_ROW_W'(cur_row);
            res.cursor_col      <= OUT_COL_W'(cur_col);
            res.cursor_position <= OUT_POS_W'(cell_pos(cur_row, cur_col));
            res.scrolled        <= scrolled;
            res.cell_data       <= read_data;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
